/* hdl/rtp_pkg.sv */
// shared constants, control struct and arctangent table for the rectangular-to-polar converter
package rtp_pkg;

   localparam int GUARD_BITS   = 24;
   localparam int PHASE_WIDTH  = 32;
   localparam int LENGTH_WIDTH = 16;

   localparam logic [LENGTH_WIDTH-1:0] LENGTH_MAX = '1;

   localparam logic [PHASE_WIDTH-1:0] ZERO_TURN      = 32'h0000_0000;
   localparam logic [PHASE_WIDTH-1:0] QUARTER_TURN   = 32'h4000_0000;
   localparam logic [PHASE_WIDTH-1:0] HALF_TURN      = 32'h8000_0000;
   localparam logic [PHASE_WIDTH-1:0] THREE_QUARTERS = 32'hC000_0000;

   typedef struct packed {
      logic valid;
      logic fixed;
   } ctrl_type;

   // round(atan(2^-i) / (2 pi) * 2^32)
   function automatic logic [PHASE_WIDTH-1:0] atan_entry(input logic [4:0] idx);
      logic [PHASE_WIDTH-1:0] val;
      unique case (idx)
         5'd0:  val = 32'd536870912;
         5'd1:  val = 32'd316933406;
         5'd2:  val = 32'd167458907;
         5'd3:  val = 32'd85004756;
         5'd4:  val = 32'd42667331;
         5'd5:  val = 32'd21354465;
         5'd6:  val = 32'd10679838;
         5'd7:  val = 32'd5340245;
         5'd8:  val = 32'd2670163;
         5'd9:  val = 32'd1335087;
         5'd10: val = 32'd667544;
         5'd11: val = 32'd333772;
         5'd12: val = 32'd166886;
         5'd13: val = 32'd83443;
         5'd14: val = 32'd41722;
         5'd15: val = 32'd20861;
         5'd16: val = 32'd10430;
         5'd17: val = 32'd5215;
         5'd18: val = 32'd2608;
         5'd19: val = 32'd1304;
         5'd20: val = 32'd652;
         5'd21: val = 32'd326;
         5'd22: val = 32'd163;
         5'd23: val = 32'd81;
         5'd24: val = 32'd41;
         5'd25: val = 32'd20;
         5'd26: val = 32'd10;
         5'd27: val = 32'd5;
         5'd28: val = 32'd3;
         5'd29: val = 32'd1;
         5'd30: val = 32'd1;
         5'd31: val = 32'd0;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

/* hdl/rtp_if.sv */
// valid/ready channel interfaces for vector requests and polar responses

interface rtp_req_if #(
   parameter int COORD_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] x_in;
   logic signed [COORD_WIDTH-1:0] y_in;

   modport source (output valid, output x_in, output y_in, input ready);
   modport sink (input valid, input x_in, input y_in, output ready);
endinterface

interface rtp_rsp_if import rtp_pkg::*; #(
   parameter int ANGLE_WIDTH = 16
);
   logic                    valid;
   logic                    ready;
   logic [LENGTH_WIDTH-1:0] length;
   logic [ANGLE_WIDTH-1:0]  heading;

   modport source (output valid, output length, output heading, input ready);
   modport sink (input valid, input length, input heading, output ready);
endinterface

/* hdl/rtp_prep.sv */
// front stages: sign folding, special cases, squaring and sum of squares
module rtp_prep import rtp_pkg::*; #(
   parameter int COORD_WIDTH = 16,
   parameter int DATA_WIDTH  = COORD_WIDTH + GUARD_BITS + 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH-1:0] x_in,
   input  logic signed [COORD_WIDTH-1:0] y_in,
   output ctrl_type                      ctrl_out,
   output logic signed [DATA_WIDTH-1:0]  x_out,
   output logic signed [DATA_WIDTH-1:0]  y_out,
   output logic [PHASE_WIDTH-1:0]        z_out,
   output logic [2*COORD_WIDTH-1:0]      n_out
);

   localparam int CW  = COORD_WIDTH;
   localparam int PAD = DATA_WIDTH - CW - 1 - GUARD_BITS;

   logic                  x_neg, y_neg, x_zero, y_zero;
   logic signed [CW:0]    xe, ye, xa, ya, xr, yr;
   logic [PHASE_WIDTH-1:0] z1_in;

   ctrl_type                     c1_ff, c2_ff, c3_ff;
   logic signed [DATA_WIDTH-1:0] x1_ff, y1_ff, x2_ff, y2_ff, x3_ff, y3_ff;
   logic [PHASE_WIDTH-1:0]       z1_ff, z2_ff, z3_ff;
   logic [CW-1:0]                ax1_ff, ay1_ff;
   logic [2*CW-1:0]              sqx2_in, sqy2_in, sqx2_ff, sqy2_ff;
   logic [2*CW-1:0]              n3_in, n3_ff;

   always_comb begin
      x_neg  = x_in[CW-1];
      y_neg  = y_in[CW-1];
      x_zero = (x_in == '0);
      y_zero = (y_in == '0);
      xe     = {x_in[CW-1], x_in};
      ye     = {y_in[CW-1], y_in};
      xa     = x_neg ? -xe : xe;
      ya     = y_neg ? -ye : ye;
      // left half plane: rotate by a half turn first
      xr     = xa;
      yr     = x_neg ? -ye : ye;
      priority if (x_zero) begin
         z1_in = y_neg ? THREE_QUARTERS : QUARTER_TURN;
      end else if (y_zero) begin
         z1_in = x_neg ? HALF_TURN : ZERO_TURN;
      end else begin
         z1_in = x_neg ? HALF_TURN : ZERO_TURN;
      end
      sqx2_in = (2*CW)'(ax1_ff) * (2*CW)'(ax1_ff);
      sqy2_in = (2*CW)'(ay1_ff) * (2*CW)'(ay1_ff);
      n3_in   = sqx2_ff + sqy2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
      end else if (en) begin
         c1_ff.valid <= in_valid;
         c1_ff.fixed <= x_zero || y_zero;
         c2_ff       <= c1_ff;
         c3_ff       <= c2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff       <= {{PAD{xr[CW]}}, xr, {GUARD_BITS{1'b0}}};
         y1_ff       <= {{PAD{yr[CW]}}, yr, {GUARD_BITS{1'b0}}};
         z1_ff       <= z1_in;
         ax1_ff      <= xa[CW-1:0];
         ay1_ff      <= ya[CW-1:0];

         x2_ff       <= x1_ff;
         y2_ff       <= y1_ff;
         z2_ff       <= z1_ff;
         sqx2_ff     <= sqx2_in;
         sqy2_ff     <= sqy2_in;

         x3_ff       <= x2_ff;
         y3_ff       <= y2_ff;
         z3_ff       <= z2_ff;
         n3_ff       <= n3_in;
      end
   end

   assign ctrl_out = c3_ff;
   assign x_out    = x3_ff;
   assign y_out    = y3_ff;
   assign z_out    = z3_ff;
   assign n_out    = n3_ff;

endmodule

/* hdl/rtp_stage.sv */
// one pipeline stage: a cordic vectoring micro-rotation and/or one square root digit, by INDEX
module rtp_stage import rtp_pkg::*; #(
   parameter int COORD_WIDTH     = 16,
   parameter int ROTATION_STAGES = 16,
   parameter int INDEX           = 0,
   parameter int DATA_WIDTH      = COORD_WIDTH + GUARD_BITS + 3
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  ctrl_type                     ctrl_in,
   input  logic signed [DATA_WIDTH-1:0] x_in,
   input  logic signed [DATA_WIDTH-1:0] y_in,
   input  logic [PHASE_WIDTH-1:0]       z_in,
   input  logic [2*COORD_WIDTH-1:0]     n_in,
   input  logic [COORD_WIDTH-1:0]       root_in,
   input  logic [COORD_WIDTH+1:0]       rem_in,
   output ctrl_type                     ctrl_out,
   output logic signed [DATA_WIDTH-1:0] x_out,
   output logic signed [DATA_WIDTH-1:0] y_out,
   output logic [PHASE_WIDTH-1:0]       z_out,
   output logic [2*COORD_WIDTH-1:0]     n_out,
   output logic [COORD_WIDTH-1:0]       root_out,
   output logic [COORD_WIDTH+1:0]       rem_out
);

   localparam int CW = COORD_WIDTH;
   localparam int RW = COORD_WIDTH + 2;

   ctrl_type                     ctrl_ff;
   logic signed [DATA_WIDTH-1:0] x_nx, y_nx, x_ff, y_ff;
   logic [PHASE_WIDTH-1:0]       z_nx, z_ff;
   logic [2*CW-1:0]              n_nx, n_ff;
   logic [CW-1:0]                root_nx, root_ff;
   logic [RW-1:0]                rem_nx, rem_ff;

   generate
      if (INDEX < ROTATION_STAGES) begin : g_rot
         logic signed [DATA_WIDTH-1:0] xs, ys;
         logic [PHASE_WIDTH-1:0]       step;
         always_comb begin
            xs   = x_in >>> INDEX;
            ys   = y_in >>> INDEX;
            step = atan_entry(5'(INDEX));
            // axis-aligned inputs keep the phase they were given
            if (ctrl_in.fixed) begin
               x_nx = x_in;
               y_nx = y_in;
               z_nx = z_in;
            end else if (!y_in[DATA_WIDTH-1]) begin
               x_nx = x_in + ys;
               y_nx = y_in - xs;
               z_nx = z_in + step;
            end else begin
               x_nx = x_in - ys;
               y_nx = y_in + xs;
               z_nx = z_in - step;
            end
         end
      end else begin : g_no_rot
         assign x_nx = x_in;
         assign y_nx = y_in;
         assign z_nx = z_in;
      end

      if (INDEX < COORD_WIDTH) begin : g_sqrt
         logic [RW-1:0] rem_sh, trial;
         always_comb begin
            // bring down the next two bits of the radicand
            rem_sh = {rem_in[RW-3:0], n_in[2*CW-1 -: 2]};
            trial  = {root_in, 2'b01};
            n_nx   = {n_in[2*CW-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_nx  = rem_sh - trial;
               root_nx = {root_in[CW-2:0], 1'b1};
            end else begin
               rem_nx  = rem_sh;
               root_nx = {root_in[CW-2:0], 1'b0};
            end
         end
      end else begin : g_no_sqrt
         assign n_nx    = n_in;
         assign root_nx = root_in;
         assign rem_nx  = rem_in;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff          <= x_nx;
         y_ff          <= y_nx;
         z_ff          <= z_nx;
         n_ff          <= n_nx;
         root_ff       <= root_nx;
         rem_ff        <= rem_nx;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign x_out    = x_ff;
   assign y_out    = y_ff;
   assign z_out    = z_ff;
   assign n_out    = n_ff;
   assign root_out = root_ff;
   assign rem_out  = rem_ff;

endmodule

/* hdl/rtp_final.sv */
// output register: length rounding and saturation, heading rounding and wrap
module rtp_final import rtp_pkg::*; #(
   parameter int COORD_WIDTH = 16,
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  ctrl_type                ctrl_in,
   input  logic [PHASE_WIDTH-1:0]  z_in,
   input  logic [COORD_WIDTH-1:0]  root_in,
   input  logic [COORD_WIDTH+1:0]  rem_in,
   output logic                    valid_out,
   output logic [LENGTH_WIDTH-1:0] length_out,
   output logic [ANGLE_WIDTH-1:0]  heading_out
);

   localparam int EW = COORD_WIDTH + 1;

   logic [EW-1:0]             rounded;
   logic [LENGTH_WIDTH-1:0]   length_in;
   logic [ANGLE_WIDTH-1:0]    heading_in;
   logic                      valid_ff;
   logic [LENGTH_WIDTH-1:0]   length_ff;
   logic [ANGLE_WIDTH-1:0]    heading_ff;

   always_comb begin
      // round up when the remainder exceeds the root (never exactly one half)
      rounded = EW'(root_in) + ((rem_in > (COORD_WIDTH + 2)'(root_in)) ? EW'(1) : EW'(0));
      if (rounded > EW'(LENGTH_MAX)) begin
         length_in = LENGTH_MAX;
      end else begin
         length_in = LENGTH_WIDTH'(rounded);
      end
   end

   generate
      if (ANGLE_WIDTH >= PHASE_WIDTH) begin : g_full
         assign heading_in = ANGLE_WIDTH'(z_in);
      end else begin : g_round
         logic [PHASE_WIDTH:0] zr;
         assign zr = {1'b0, z_in}
                   + (PHASE_WIDTH + 1)'(64'd1 << (PHASE_WIDTH - 1 - ANGLE_WIDTH));
         // carry out of the top is a full turn and drops away
         assign heading_in = zr[PHASE_WIDTH-1 -: ANGLE_WIDTH];
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= ctrl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         length_ff  <= length_in;
         heading_ff <= heading_in;
      end
   end

   assign valid_out   = valid_ff;
   assign length_out  = length_ff;
   assign heading_out = heading_ff;

endmodule

/* hdl/rect_to_polar_vector.sv */
// top level: pipelined rectangular-to-polar converter
// Accepts one signed (x, y) vector per clock and returns its rounded Euclidean length and its
// heading over a full turn in units of 2 pi / 2^ANGLE_WIDTH. In order, the pipeline holds
// three front stages (sign folding, squaring, sum), D = max(ROTATION_STAGES, COORD_WIDTH)
// stages, the first ROTATION_STAGES doing a cordic micro-rotation and the first COORD_WIDTH
// a square root digit, and the output register. Throughput is one transaction per cycle while
// responses are taken; when the response side holds off, the whole pipeline freezes and req
// ready drops until the waiting response is taken; nothing is lost or repeated. There is no
// configuration and no state beyond the pipeline contents; reset only clears its control bits.
module rect_to_polar_vector import rtp_pkg::*; #(
   parameter int COORD_WIDTH     = 16,
   parameter int ANGLE_WIDTH     = 16,
   parameter int ROTATION_STAGES = 16
) (
   input  logic      clock,
   input  logic      reset,
   rtp_req_if.sink   req_if,
   rtp_rsp_if.source rsp_if
);

   localparam int DEPTH      = (ROTATION_STAGES > COORD_WIDTH) ? ROTATION_STAGES : COORD_WIDTH;
   localparam int DATA_WIDTH = COORD_WIDTH + GUARD_BITS + 3;

   logic en;

   ctrl_type                     ctrl_w [DEPTH+1];
   logic signed [DATA_WIDTH-1:0] x_w    [DEPTH+1];
   logic signed [DATA_WIDTH-1:0] y_w    [DEPTH+1];
   logic [PHASE_WIDTH-1:0]       z_w    [DEPTH+1];
   logic [2*COORD_WIDTH-1:0]     n_w    [DEPTH+1];
   logic [COORD_WIDTH-1:0]       root_w [DEPTH+1];
   logic [COORD_WIDTH+1:0]       rem_w  [DEPTH+1];
   logic [DEPTH:0]               vld_w;

   // the whole pipeline advances unless a finished response is waiting
   assign en           = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = en;

   rtp_prep #(
      .COORD_WIDTH (COORD_WIDTH),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_if.valid),
      .x_in     (req_if.x_in),
      .y_in     (req_if.y_in),
      .ctrl_out (ctrl_w[0]),
      .x_out    (x_w[0]),
      .y_out    (y_w[0]),
      .z_out    (z_w[0]),
      .n_out    (n_w[0])
   );

   assign root_w[0] = '0;
   assign rem_w[0]  = '0;

   generate
      for (genvar k = 0; k < DEPTH; k++) begin : g_stage
         rtp_stage #(
            .COORD_WIDTH     (COORD_WIDTH),
            .ROTATION_STAGES (ROTATION_STAGES),
            .INDEX           (k),
            .DATA_WIDTH      (DATA_WIDTH)
         ) u_stage (
            .clock    (clock),
            .reset    (reset),
            .en       (en),
            .ctrl_in  (ctrl_w[k]),
            .x_in     (x_w[k]),
            .y_in     (y_w[k]),
            .z_in     (z_w[k]),
            .n_in     (n_w[k]),
            .root_in  (root_w[k]),
            .rem_in   (rem_w[k]),
            .ctrl_out (ctrl_w[k+1]),
            .x_out    (x_w[k+1]),
            .y_out    (y_w[k+1]),
            .z_out    (z_w[k+1]),
            .n_out    (n_w[k+1]),
            .root_out (root_w[k+1]),
            .rem_out  (rem_w[k+1])
         );
      end

      for (genvar k = 0; k <= DEPTH; k++) begin : g_vld
         assign vld_w[k] = ctrl_w[k].valid;
      end
   endgenerate

   rtp_final #(
      .COORD_WIDTH (COORD_WIDTH),
      .ANGLE_WIDTH (ANGLE_WIDTH)
   ) u_final (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .ctrl_in     (ctrl_w[DEPTH]),
      .z_in        (z_w[DEPTH]),
      .root_in     (root_w[DEPTH]),
      .rem_in      (rem_w[DEPTH]),
      .valid_out   (rsp_if.valid),
      .length_out  (rsp_if.length),
      .heading_out (rsp_if.heading)
   );

   // a stall freezes every stage's valid bit
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_w))
      else $error("pipeline valid bits moved during a stall");

   // the response register only fills from the last stage
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (en && !vld_w[DEPTH]) |=> !rsp_if.valid)
      else $error("response appeared with no transaction in the last stage");

   // only the zero vector has zero length, and it points a quarter turn
   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.length == '0)
      |-> (rsp_if.heading == (ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2))))
      else $error("zero vector gave a heading other than a quarter turn");

endmodule
